// ----- hw/rtl/rmq_pkg.sv -----
// Shared types and constants for the rotation matrix to quaternion block.
// No dependencies; imported by every module of the block.
package rmq_pkg;

	localparam int DATA_WIDTH_DEF = 16;

	typedef enum logic [1:0] {
		BR_TRACE = 2'd0,
		BR_X     = 2'd1,
		BR_Y     = 2'd2,
		BR_Z     = 2'd3
	} branch_t;

endpackage

// ----- hw/rtl/rmq_front.sv -----
// Front end: branch selection, radicand and numerators (two register stages).
// Depends on rmq_pkg.
module rmq_front #(
	parameter int W = rmq_pkg::DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  logic                  v_in,
	input  logic signed [W-1:0]   m00, m01, m02, m10, m11, m12, m20, m21, m22,
	output logic                  v_s2,
	output rmq_pkg::branch_t      br_s2,
	output logic                  degen_s2,
	output logic [2*W-4:0]        x_s2,
	output logic signed [W:0]     n0_s2,
	output logic signed [W:0]     n1_s2,
	output logic signed [W:0]     n2_s2
);
	import rmq_pkg::*;

	localparam logic signed [W+1:0] ONE = {3'b000, 1'b1, {(W-2){1'b0}}};

	logic signed [W+1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
	logic signed [W+1:0] tr, rad, t0, t1, t2;
	branch_t             br;

	logic                v_s1;
	branch_t             br_s1;
	logic signed [W+1:0] rad_s1;
	logic signed [W:0]   n0_s1, n1_s1, n2_s1;

	assign e00 = (W+2)'(m00);
	assign e01 = (W+2)'(m01);
	assign e02 = (W+2)'(m02);
	assign e10 = (W+2)'(m10);
	assign e11 = (W+2)'(m11);
	assign e12 = (W+2)'(m12);
	assign e20 = (W+2)'(m20);
	assign e21 = (W+2)'(m21);
	assign e22 = (W+2)'(m22);
	assign tr  = e00 + e11 + e22;

	// strict compares: earlier diagonal wins only when strictly larger
	always_comb begin
		if (tr > 0) begin
			br  = BR_TRACE;
			rad = tr + ONE;
			t0  = e21 - e12;
			t1  = e02 - e20;
			t2  = e10 - e01;
		end else if (e00 > e11 && e00 > e22) begin
			br  = BR_X;
			rad = ONE + e00 - e11 - e22;
			t0  = e21 - e12;
			t1  = e01 + e10;
			t2  = e02 + e20;
		end else if (e11 > e22) begin
			br  = BR_Y;
			rad = ONE + e11 - e00 - e22;
			t0  = e02 - e20;
			t1  = e01 + e10;
			t2  = e12 + e21;
		end else begin
			br  = BR_Z;
			rad = ONE + e22 - e00 - e11;
			t0  = e10 - e01;
			t1  = e02 + e20;
			t2  = e12 + e21;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			br_s1    <= br;
			rad_s1   <= rad;
			n0_s1    <= t0[W:0];
			n1_s1    <= t1[W:0];
			n2_s1    <= t2[W:0];
			br_s2    <= br_s1;
			degen_s2 <= rad_s1[W+1] || (rad_s1 == '0);
			// radicand scaled by 2^(FRAC-2); positive radicand fits W+1 bits
			x_s2     <= {rad_s1[W:0], {(W-4){1'b0}}};
			n0_s2    <= n0_s1;
			n1_s2    <= n1_s1;
			n2_s2    <= n2_s1;
		end
	end

endmodule

// ----- hw/rtl/rmq_sqrt.sv -----
// Pipelined integer square root, one root bit per stage, side word carried along.
// Depends on rmq_pkg.
module rmq_sqrt #(
	parameter int W      = rmq_pkg::DATA_WIDTH_DEF,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              v_in,
	input  logic [2*W-4:0]    x_in,
	input  logic [SIDE_W-1:0] side_in,
	output logic              v_out,
	output logic [W-2:0]      root_out,
	output logic [SIDE_W-1:0] side_out
);
	import rmq_pkg::*;

	localparam int RB = W - 1;
	localparam int RW = RB + 3;

	logic              v_s    [RB];
	logic [RW-1:0]     rem_s  [RB];
	logic [RB-1:0]     root_s [RB];
	logic [2*RB-1:0]   xp_s   [RB];
	logic [SIDE_W-1:0] side_s [RB];

	for (genvar k = 0; k < RB; k++) begin : g_stg
		logic              v_p;
		logic [RW-1:0]     rem_p, rem_sh, trial;
		logic [RB-1:0]     root_p;
		logic [2*RB-1:0]   xp_p;
		logic [SIDE_W-1:0] side_p;

		if (k == 0) begin : g_first
			assign v_p    = v_in;
			assign rem_p  = '0;
			assign root_p = '0;
			assign xp_p   = {1'b0, x_in};
			assign side_p = side_in;
		end else begin : g_next
			assign v_p    = v_s[k-1];
			assign rem_p  = rem_s[k-1];
			assign root_p = root_s[k-1];
			assign xp_p   = xp_s[k-1];
			assign side_p = side_s[k-1];
		end

		assign rem_sh = {rem_p[RW-3:0], xp_p[2*RB-1-2*k -: 2]};
		assign trial  = RW'({root_p, 2'b01});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (adv) begin
				v_s[k] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				xp_s[k]   <= xp_p;
				side_s[k] <= side_p;
				if (rem_sh >= trial) begin
					rem_s[k]  <= rem_sh - trial;
					root_s[k] <= {root_p[RB-2:0], 1'b1};
				end else begin
					rem_s[k]  <= rem_sh;
					root_s[k] <= {root_p[RB-2:0], 1'b0};
				end
			end
		end
	end

	assign v_out    = v_s[RB-1];
	assign root_out = root_s[RB-1];
	assign side_out = side_s[RB-1];

endmodule

// ----- hw/rtl/rmq_div.sv -----
// Pipelined restoring divider: round(mag * 2^FRAC / (4*main)), one quotient bit per
// stage, with overflow flag for saturation. Depends on rmq_pkg.
module rmq_div #(
	parameter int W      = rmq_pkg::DATA_WIDTH_DEF,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              v_in,
	input  logic [W:0]        mag_in,
	input  logic [W-2:0]      main_in,
	input  logic [SIDE_W-1:0] side_in,
	output logic              v_out,
	output logic [W-1:0]      q_out,
	output logic              ovf_out,
	output logic [SIDE_W-1:0] side_out
);
	import rmq_pkg::*;

	localparam int DW = 2 * W;

	logic [DW-1:0]     dvd;
	logic [W:0]        den;

	logic              v_s0, ovf_s0;
	logic [DW-1:0]     rem_s0;
	logic [W:0]        den_s0;
	logic [SIDE_W-1:0] side_s0;

	logic              v_s    [W];
	logic              ovf_s  [W];
	logic [DW-1:0]     rem_s  [W];
	logic [W:0]        den_s  [W];
	logic [W-1:0]      q_s    [W];
	logic [SIDE_W-1:0] side_s [W];

	// dividend = mag << FRAC plus half the divisor for round-half-up on magnitude
	assign den = {main_in, 2'b00};
	assign dvd = DW'({mag_in, {(W-2){1'b0}}}) + DW'({main_in, 1'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0;
		end else if (adv) begin
			v_s0 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rem_s0  <= dvd;
			den_s0  <= den;
			side_s0 <= side_in;
			ovf_s0  <= (DW+1)'(dvd) >= {den, {W{1'b0}}};
		end
	end

	for (genvar j = 0; j < W; j++) begin : g_stg
		logic              v_p, ovf_p;
		logic [DW-1:0]     rem_p, dsh;
		logic [W:0]        den_p;
		logic [W-1:0]      q_p;
		logic [SIDE_W-1:0] side_p;

		if (j == 0) begin : g_first
			assign v_p    = v_s0;
			assign ovf_p  = ovf_s0;
			assign rem_p  = rem_s0;
			assign den_p  = den_s0;
			assign q_p    = '0;
			assign side_p = side_s0;
		end else begin : g_next
			assign v_p    = v_s[j-1];
			assign ovf_p  = ovf_s[j-1];
			assign rem_p  = rem_s[j-1];
			assign den_p  = den_s[j-1];
			assign q_p    = q_s[j-1];
			assign side_p = side_s[j-1];
		end

		assign dsh = DW'(den_p) << (W - 1 - j);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (adv) begin
				v_s[j] <= v_p;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				ovf_s[j]  <= ovf_p;
				den_s[j]  <= den_p;
				side_s[j] <= side_p;
				if (rem_p >= dsh) begin
					rem_s[j] <= rem_p - dsh;
					q_s[j]   <= {q_p[W-2:0], 1'b1};
				end else begin
					rem_s[j] <= rem_p;
					q_s[j]   <= {q_p[W-2:0], 1'b0};
				end
			end
		end
	end

	assign v_out    = v_s[W-1];
	assign q_out    = q_s[W-1];
	assign ovf_out  = ovf_s[W-1];
	assign side_out = side_s[W-1];

endmodule

// ----- hw/rtl/rotation_matrix_to_quaternion.sv -----
// Rotation matrix (Q2.FRAC) to unit quaternion, trace-branch method, fully pipelined.
// Depends on rmq_pkg, rmq_front, rmq_sqrt, rmq_div.
//
// Input channel: in_valid / in_stall with the nine matrix entries m00..m22.
// Output channel: out_valid / out_stall with q_scalar, q_i, q_j, q_k, branch_taken
// and degenerate. A word moves when valid is high and stall is low.
// Throughput: one matrix per cycle while the output word is not stalled. Pipeline:
// two front stages, DATA_WIDTH-1 square root stages (one root bit each), one
// divider setup stage, DATA_WIDTH divider stages (one quotient bit each) and the
// output register.
// When the receiver stalls a valid output word, the whole pipeline freezes and
// in_stall is raised in the same cycle; nothing is dropped or repeated.
// Empty slots keep moving as long as the output word is not stalled.
// Reset clears all valid bits; the pipeline is empty and ready after reset.
// A non-positive radicand gives the identity quaternion with degenerate set.
module rotation_matrix_to_quaternion #(
	parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [DATA_WIDTH-1:0] m00, m01, m02,
	input  logic signed [DATA_WIDTH-1:0] m10, m11, m12,
	input  logic signed [DATA_WIDTH-1:0] m20, m21, m22,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [DATA_WIDTH-1:0] q_scalar,
	output logic signed [DATA_WIDTH-1:0] q_i,
	output logic signed [DATA_WIDTH-1:0] q_j,
	output logic signed [DATA_WIDTH-1:0] q_k,
	output logic [1:0]                   branch_taken,
	output logic                         degenerate
);
	import rmq_pkg::*;

	localparam int W     = DATA_WIDTH;
	localparam int SQ_SW = 3 + 3 * (W + 1);
	localparam int D0_SW = 3 + (W - 1) + 1;
	localparam logic [W-1:0] ONE  = {2'b01, {(W-2){1'b0}}};
	localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

	logic adv;

	logic              v_f;
	branch_t           br_f;
	logic              degen_f;
	logic [2*W-4:0]    x_f;
	logic signed [W:0] n0_f, n1_f, n2_f;

	logic              v_r;
	logic [W-2:0]      root_r;
	logic [SQ_SW-1:0]  side_r;
	branch_t           br_r;
	logic              degen_r;
	logic signed [W:0] n0_r, n1_r, n2_r;
	logic [W:0]        mag0, mag1, mag2;

	logic              v_d0, v_d1, v_d2;
	logic [W-1:0]      q0, q1, q2;
	logic              ovf0, ovf1, ovf2;
	logic [D0_SW-1:0]  side_d0;
	logic              sgn1, sgn2;
	logic [2:0]        bd_d;
	logic [W-2:0]      main_d;
	branch_t           br_d;
	logic [W-1:0]      pa, pb, pc, mp;
	logic [W-1:0]      qs_n, qi_n, qj_n, qk_n;

	function automatic logic [W-1:0] fin(input logic neg, input logic ovf,
		input logic [W-1:0] q);
		logic [W-1:0] r;
		if (neg) begin
			r = (ovf || q > SMIN) ? SMIN : (~q + 1'b1);
		end else begin
			r = (ovf || q > SMAX) ? SMAX : q;
		end
		return r;
	endfunction

	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	rmq_front #(.W(W)) u_front (
		.clk(clk), .arst_n(arst_n), .adv(adv), .v_in(in_valid),
		.m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
		.m20(m20), .m21(m21), .m22(m22),
		.v_s2(v_f), .br_s2(br_f), .degen_s2(degen_f), .x_s2(x_f),
		.n0_s2(n0_f), .n1_s2(n1_f), .n2_s2(n2_f)
	);

	rmq_sqrt #(.W(W), .SIDE_W(SQ_SW)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .adv(adv), .v_in(v_f), .x_in(x_f),
		.side_in({br_f, degen_f, n0_f, n1_f, n2_f}),
		.v_out(v_r), .root_out(root_r), .side_out(side_r)
	);

	assign br_r    = branch_t'(side_r[SQ_SW-1 -: 2]);
	assign degen_r = side_r[SQ_SW-3];
	assign n0_r    = side_r[3*(W+1)-1 -: W+1];
	assign n1_r    = side_r[2*(W+1)-1 -: W+1];
	assign n2_r    = side_r[W:0];
	assign mag0    = n0_r[W] ? (~n0_r + 1'b1) : n0_r;
	assign mag1    = n1_r[W] ? (~n1_r + 1'b1) : n1_r;
	assign mag2    = n2_r[W] ? (~n2_r + 1'b1) : n2_r;

	// degenerate items carry no meaningful root; the divider result is discarded then
	rmq_div #(.W(W), .SIDE_W(D0_SW)) u_div0 (
		.clk(clk), .arst_n(arst_n), .adv(adv), .v_in(v_r), .mag_in(mag0),
		.main_in(root_r), .side_in({br_r, degen_r, root_r, n0_r[W]}),
		.v_out(v_d0), .q_out(q0), .ovf_out(ovf0), .side_out(side_d0)
	);

	rmq_div #(.W(W), .SIDE_W(1)) u_div1 (
		.clk(clk), .arst_n(arst_n), .adv(adv), .v_in(v_r), .mag_in(mag1),
		.main_in(root_r), .side_in(n1_r[W]),
		.v_out(v_d1), .q_out(q1), .ovf_out(ovf1), .side_out(sgn1)
	);

	rmq_div #(.W(W), .SIDE_W(1)) u_div2 (
		.clk(clk), .arst_n(arst_n), .adv(adv), .v_in(v_r), .mag_in(mag2),
		.main_in(root_r), .side_in(n2_r[W]),
		.v_out(v_d2), .q_out(q2), .ovf_out(ovf2), .side_out(sgn2)
	);

	assign bd_d   = side_d0[D0_SW-1 -: 3];
	assign br_d   = branch_t'(bd_d[2:1]);
	assign main_d = side_d0[W-1:1];
	assign pa     = fin(side_d0[0], ovf0, q0);
	assign pb     = fin(sgn1, ovf1, q1);
	assign pc     = fin(sgn2, ovf2, q2);
	assign mp     = {1'b0, main_d};

	always_comb begin
		qs_n = pa;
		qi_n = pb;
		qj_n = pc;
		qk_n = mp;
		if (bd_d[0]) begin
			qs_n = ONE;
			qi_n = '0;
			qj_n = '0;
			qk_n = '0;
		end else begin
			unique case (br_d)
				BR_TRACE: begin
					qs_n = mp; qi_n = pa; qj_n = pb; qk_n = pc;
				end
				BR_X: begin
					qs_n = pa; qi_n = mp; qj_n = pb; qk_n = pc;
				end
				BR_Y: begin
					qs_n = pa; qi_n = pb; qj_n = mp; qk_n = pc;
				end
				default: begin
					qs_n = pa; qi_n = pb; qj_n = pc; qk_n = mp;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= v_d0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			q_scalar     <= qs_n;
			q_i          <= qi_n;
			q_j          <= qj_n;
			q_k          <= qk_n;
			branch_taken <= br_d;
			degenerate   <= bd_d[0];
		end
	end

	a_lanes_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(v_d0 == v_d1) && (v_d0 == v_d2))
		else $error("divider lanes out of step");

	a_stall_only_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall without a held output word");

	a_degen_identity: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |-> q_scalar == ONE && q_i == '0 && q_j == '0 && q_k == '0)
		else $error("degenerate word is not the identity");

	a_trace_not_degen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && branch_taken == BR_TRACE |-> !degenerate)
		else $error("trace branch flagged degenerate");

endmodule
